@@ rtl/lapsh_pkg.sv @@
// Shared constants and types of the 3x3 Laplacian sharpening unit.
package lapsh_pkg;

  localparam int CHAN_W        = 8;
  localparam int PIX_W         = 3 * CHAN_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 11;
  localparam int HEIGHT_W      = 11;
  localparam int ROW_W         = 10;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MIN_DIM       = 3;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  localparam int SHARPEN_GAIN  = 5;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // accepted item as decided by the position counters
  typedef struct packed {
    logic             valid;
    logic             pad;
    logic             emit;
    logic             border;
    logic             last;
    logic             sel_upper;
    logic [PIX_W-1:0] px;
  } lapsh_req_t;

  // one result pixel
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              border;
    logic              last;
  } lapsh_res_t;

endpackage

@@ rtl/lapsh_pix_if.sv @@
// Input pixel channel: valid/ready with BGR payload and padding flag.
interface lapsh_pix_if;
  import lapsh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] red_in;
  logic              padding;

  modport source (output valid, blue_in, green_in, red_in, padding, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, padding, output ready);
endinterface

@@ rtl/lapsh_res_if.sv @@
// Result pixel channel: valid/ready with BGR payload and position flags.
interface lapsh_res_if;
  import lapsh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] red_out;
  logic              is_border;
  logic              frame_end;

  modport source (output valid, blue_out, green_out, red_out, is_border, frame_end,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, is_border, frame_end,
                  output ready);
endinterface

@@ rtl/lapsh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lapsh_ram #(
  parameter int DW    = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);
  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/lapsh_ctrl.sv @@
// Frame position counters, configuration registers and per-item decisions.
module lapsh_ctrl #(
  parameter int MAX_WIDTH = lapsh_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lapsh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lapsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lapsh_pix_if.sink                       pix_i,
  input  logic                            en_i,
  output lapsh_pkg::lapsh_req_t           req_o,
  output logic                            rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    addr_o
);
  import lapsh_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam logic [WW-1:0] WidthRst =
    (FRAME_WIDTH_RST > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(FRAME_WIDTH_RST);
  localparam logic [HEIGHT_W-1:0] HeightRst = HEIGHT_W'(FRAME_HEIGHT_RST);

  logic [WW-1:0]       width_q, cfg_width, wm1, ocol;
  logic [HEIGHT_W-1:0] height_q, cfg_height, hm1, row_ext, orow;
  logic [CW-1:0]       col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [PW-1:0]       pend_q, pend_d, pad_col;
  logic                cfg_hit, accept, col_last, row_last, pend_full;
  logic                emit_pad, sel_upper;

  assign accept      = pix_i.valid && en_i;
  assign pix_i.ready = en_i;

  // saturate written dimensions to the supported range
  always_comb begin
    if (cfg_data_i < CFG_DATA_W'(MIN_DIM)) begin
      cfg_width = WW'(MIN_DIM);
    end else if (int'(cfg_data_i) > MAX_WIDTH) begin
      cfg_width = WW'(MAX_WIDTH);
    end else begin
      cfg_width = WW'(cfg_data_i);
    end
    if (cfg_data_i < CFG_DATA_W'(MIN_DIM)) begin
      cfg_height = HEIGHT_W'(MIN_DIM);
    end else if (int'(cfg_data_i) > MAX_HEIGHT) begin
      cfg_height = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      cfg_height = HEIGHT_W'(cfg_data_i);
    end
    case (cfg_idx_i)
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: cfg_hit = cfg_we_i;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    wm1       = width_q - WW'(1);
    hm1       = height_q - HEIGHT_W'(1);
    row_ext   = HEIGHT_W'(row_q);
    col_last  = (WW'(col_q) + WW'(1)) >= width_q;
    row_last  = (row_ext + HEIGHT_W'(1)) >= height_q;
    pend_full = pend_q == (PW'(width_q) + PW'(1));

    // position of the pixel whose result this item delivers
    if (col_q != '0) begin
      orow = (row_q == '0) ? hm1 : row_ext - HEIGHT_W'(1);
      ocol = WW'(col_q) - WW'(1);
    end else begin
      orow = (row_q >= ROW_W'(2)) ? row_ext - HEIGHT_W'(2)
                                  : row_ext + height_q - HEIGHT_W'(2);
      ocol = wm1;
    end

    // padding drains owed pixels only at the start of a frame
    emit_pad  = (col_q == '0) && (row_q == '0) && (pend_q != '0);
    sel_upper = pend_q > PW'(width_q);
    pad_col   = sel_upper ? PW'(wm1) : PW'(width_q) - pend_q;

    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (pix_i.padding) begin
      if (emit_pad) begin
        pend_d = pend_q - PW'(1);
      end
    end else begin
      col_d = col_last ? '0 : col_q + CW'(1);
      if (col_last) begin
        row_d = row_last ? '0 : row_q + ROW_W'(1);
      end
      if (!pend_full) begin
        pend_d = pend_q + PW'(1);
      end
    end

    req_o.valid     = accept;
    req_o.pad       = pix_i.padding;
    req_o.sel_upper = sel_upper;
    req_o.px        = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    if (pix_i.padding) begin
      req_o.emit   = emit_pad;
      req_o.border = 1'b1;
      req_o.last   = pend_q == PW'(1);
    end else begin
      req_o.emit   = pend_full;
      req_o.border = (orow == '0) || (orow == hm1) || (ocol == '0) || (ocol == wm1);
      req_o.last   = (orow == hm1) && (ocol == wm1);
    end

    addr_o  = pix_i.padding ? CW'(pad_col) : col_q;
    rd_en_o = accept && (!pix_i.padding || emit_pad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_width;
        CFG_FRAME_HEIGHT: height_q <= cfg_height;
        default: ;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end
endmodule

@@ rtl/lapsh_datapath.sv @@
// Read-data stage: line store write-back, window, sharpening and output skid.
module lapsh_datapath #(
  parameter int MAX_WIDTH = lapsh_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lapsh_pkg::lapsh_req_t         req_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  input  logic [lapsh_pkg::PIX_W-1:0]   up_rdata_i,
  input  logic [lapsh_pkg::PIX_W-1:0]   mid_rdata_i,
  output logic                          wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  waddr_o,
  output logic [lapsh_pkg::PIX_W-1:0]   up_wdata_o,
  output logic [lapsh_pkg::PIX_W-1:0]   mid_wdata_o,
  output logic                          en_o,
  lapsh_res_if.source                   res_o
);
  import lapsh_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  function automatic logic [CHAN_W-1:0] sharpen_chan(
    input logic [CHAN_W-1:0] ctr,
    input logic [CHAN_W-1:0] n0,
    input logic [CHAN_W-1:0] n1,
    input logic [CHAN_W-1:0] n2,
    input logic [CHAN_W-1:0] n3
  );
    logic [CHAN_W+3:0] v;
    v = (CHAN_W+4)'(ctr) * (CHAN_W+4)'(SHARPEN_GAIN) - (CHAN_W+4)'(n0)
      - (CHAN_W+4)'(n1) - (CHAN_W+4)'(n2) - (CHAN_W+4)'(n3);
    if (v[CHAN_W+3]) begin
      return '0;
    end else if (v > (CHAN_W+4)'(CHAN_MAX)) begin
      return CHAN_MAX;
    end else begin
      return v[CHAN_W-1:0];
    end
  endfunction

  lapsh_req_t       req_b_q;
  logic             vld_b_q, fwd_q;
  logic [CW-1:0]    addr_b_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q, up_eff, mid_eff, res_px, sharp_px;
  logic [PIX_W-1:0] win_q [3][2];   // [row][0] older column, [row][1] newest
  lapsh_res_t       new_res, out_q, skid_q;
  logic             out_vld_q, skid_vld_q, new_vld, en;

  assign en      = !skid_vld_q;
  assign en_o    = en;
  assign up_eff  = fwd_q ? fwd_up_q  : up_rdata_i;
  assign mid_eff = fwd_q ? fwd_mid_q : mid_rdata_i;

  assign wr_en_o     = en && vld_b_q && !req_b_q.pad;
  assign waddr_o     = addr_b_q;
  assign up_wdata_o  = mid_eff;
  assign mid_wdata_o = req_b_q.px;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sharp_px[i*CHAN_W +: CHAN_W] = sharpen_chan(
        win_q[1][1][i*CHAN_W +: CHAN_W], win_q[0][1][i*CHAN_W +: CHAN_W],
        win_q[2][1][i*CHAN_W +: CHAN_W], win_q[1][0][i*CHAN_W +: CHAN_W],
        mid_eff[i*CHAN_W +: CHAN_W]);
    end
    if (req_b_q.pad) begin
      res_px = req_b_q.sel_upper ? up_eff : mid_eff;
    end else begin
      res_px = req_b_q.border ? win_q[1][1] : sharp_px;
    end
    new_res.blue   = res_px[0*CHAN_W +: CHAN_W];
    new_res.green  = res_px[1*CHAN_W +: CHAN_W];
    new_res.red    = res_px[2*CHAN_W +: CHAN_W];
    new_res.border = req_b_q.border;
    new_res.last   = req_b_q.last;
    new_vld        = en && vld_b_q && req_b_q.emit;
  end

  // stage registers; forward the write-back when the new item reads the same entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else if (en) begin
      vld_b_q <= req_i.valid;
      fwd_q   <= req_i.valid && wr_en_o && (addr_b_q == addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && req_i.valid) begin
      req_b_q   <= req_i;
      addr_b_q  <= addr_i;
      fwd_up_q  <= mid_eff;
      fwd_mid_q <= req_b_q.px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= '0;
        win_q[i][1] <= '0;
      end
    end else if (wr_en_o) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
      end
      win_q[0][1] <= up_eff;
      win_q[1][1] <= mid_eff;
      win_q[2][1] <= req_b_q.px;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (res_o.ready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (new_vld) begin
      if (out_vld_q && !res_o.ready) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (res_o.ready) begin
        out_q <= skid_q;
      end
    end else if (new_vld) begin
      if (out_vld_q && !res_o.ready) begin
        skid_q <= new_res;
      end else begin
        out_q <= new_res;
      end
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.blue_out  = out_q.blue;
  assign res_o.green_out = out_q.green;
  assign res_o.red_out   = out_q.red;
  assign res_o.is_border = out_q.border;
  assign res_o.frame_end = out_q.last;
endmodule

@@ rtl/laplacian_sharpen_3x3_rgb_unit.sv @@
// Top level: 3x3 Laplacian sharpening of a raster BGR stream over two line stores.
// Throughput: one item per clock sustained while no result waits in the skid entry;
//   each pixel does one read and one write on each line store, which sets that figure.
// Latency: a released result passes the read-data stage register and then the
//   output register; results trail the input by frame_width+1 pixels.
// Reset: counters and window cleared, 640x480 frame; line stores not cleared.
module laplacian_sharpen_3x3_rgb_unit #(
  parameter int MAX_WIDTH = lapsh_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lapsh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lapsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lapsh_pix_if.sink                       pix_i,
  lapsh_res_if.source                     res_o
);
  import lapsh_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  lapsh_req_t       req;
  logic             rd_en, wr_en, en;
  logic [CW-1:0]    rd_addr, wr_addr;
  logic [PIX_W-1:0] up_rdata, mid_rdata, up_wdata, mid_wdata;

  // Counters decide per transfer whether a result is owed, where it lies in
  // the frame and which line store entry to read.
  lapsh_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .en_i       (en),
    .req_o      (req),
    .rd_en_o    (rd_en),
    .addr_o     (rd_addr)
  );

  // Upper line store: row two above the incoming pixel.
  lapsh_ram #(.DW(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (up_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (up_rdata)
  );

  // Middle line store: row directly above the incoming pixel.
  lapsh_ram #(.DW(PIX_W), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (mid_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (mid_rdata)
  );

  // Registered read data arrives here: write-back (read-modify-write of
  // both stores at one column), window shift and the sharpened result. The
  // only same-entry overlap is a padding item reading the column written by
  // the last pixel of a frame; that is forwarded inside.
  lapsh_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .addr_i      (rd_addr),
    .up_rdata_i  (up_rdata),
    .mid_rdata_i (mid_rdata),
    .wr_en_o     (wr_en),
    .waddr_o     (wr_addr),
    .up_wdata_o  (up_wdata),
    .mid_wdata_o (mid_wdata),
    .en_o        (en),
    .res_o       (res_o)
  );

  // line stores are only read on an input transfer
  a_read_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (pix_i.valid && pix_i.ready))
    else $error("line store read without input transfer");

  // a same-column read during write-back can only come from a padding item
  a_overlap_is_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en && (rd_addr == wr_addr)) |-> req.pad)
    else $error("pixel read collides with line store write-back");

  // the last pixel of a frame is always a border pixel
  a_frame_end_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> res_o.is_border)
    else $error("frame end flagged on an interior pixel");

  // a held result keeps the pipeline from dropping a transfer
  a_no_write_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> en)
    else $error("line store written while the pipeline is held");
endmodule
